@@ src/fcbf_pkg.sv @@
// fcbf_pkg: shared constants, opcode codes and pointer helper for the byte FIFO core.
// Used by fcbf_store and flow_controlled_byte_fifo_core; depends on nothing.
package fcbf_pkg;

  // Store geometry and burst limit
  localparam int STORE_DEPTH = 4096;
  localparam int MAX_BURST   = 64;
  localparam int ADDR_W      = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // Fixed field widths
  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int BURST_W  = 7;
  localparam int CAP_W    = 13;
  localparam int STAT_W   = 13;
  localparam int TOTAL_W  = 32;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Compare widths that cover both operands
  localparam int CMP_W     = CNT_W + BURST_W;
  localparam int CAP_CMP_W = ((CAP_W > CNT_W) ? CAP_W : CNT_W) + 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

  // Register map: bit 2 of the byte address picks the register
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DROP  = 3'd3,
    OP_CLOSE = 3'd4
  } opcode_t;

  // Ring pointer advance: p < STORE_DEPTH, k <= STORE_DEPTH, one compare and subtract
  function automatic logic [ADDR_W-1:0] ptr_add(input logic [ADDR_W-1:0] p,
                                                input logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(p) + (CNT_W + 1)'(k);
    if (sum >= (CNT_W + 1)'(STORE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(STORE_DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

endpackage

@@ src/fcbf_store.sv @@
// fcbf_store: single-port byte memory with registered read data.
// Depends on fcbf_pkg for depth and widths; read data holds until the next read.
module fcbf_store (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [fcbf_pkg::ADDR_W-1:0] addr,
  input  logic [fcbf_pkg::BYTE_W-1:0] wdata,
  output logic [fcbf_pkg::BYTE_W-1:0] rdata
);

  logic [fcbf_pkg::BYTE_W-1:0] mem [fcbf_pkg::STORE_DEPTH];
  logic [fcbf_pkg::BYTE_W-1:0] rdata_r;

  // One access per cycle: write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/flow_controlled_byte_fifo_core.sv @@
// Bounded byte FIFO core with flow control and end-of-stream marking.
// The first result beat appears in the cycle after its item is accepted; each
// further beat of a read or peek burst follows unless the output stalls. Write, close,
// drop, undefined opcodes and empty reads give one beat each; a read or peek of n bytes
// streams one byte a cycle from the single-port store while the output is free and holds
// the input off until its last byte is issued. Reset (rst_n low, synchronous) clears
// pointers, count, totals and closed flag, sets capacity to 4096, keeps store contents.
module flow_controlled_byte_fifo_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fcbf_pkg::OP_W-1:0]     in_opcode,
  input  logic [fcbf_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [fcbf_pkg::BURST_W-1:0]  in_burst_length,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fcbf_pkg::BYTE_W-1:0]   out_out_byte,
  output logic                          out_byte_valid,
  output logic                          out_last_of_run,
  output logic                          out_write_accepted,
  output logic                          out_request_clamped,
  output logic [fcbf_pkg::STAT_W-1:0]   out_buffered_count,
  output logic [fcbf_pkg::STAT_W-1:0]   out_remaining_space,
  output logic [fcbf_pkg::TOTAL_W-1:0]  out_total_written,
  output logic [fcbf_pkg::TOTAL_W-1:0]  out_total_read,
  output logic                          out_input_closed,
  output logic                          out_end_of_stream,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fcbf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [fcbf_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [fcbf_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int ADDR_W  = fcbf_pkg::ADDR_W;
  localparam int CNT_W   = fcbf_pkg::CNT_W;
  localparam int BURST_W = fcbf_pkg::BURST_W;
  localparam int CAP_W   = fcbf_pkg::CAP_W;
  localparam int STAT_W  = fcbf_pkg::STAT_W;
  localparam int TOTAL_W = fcbf_pkg::TOTAL_W;
  localparam int BYTE_W  = fcbf_pkg::BYTE_W;

  typedef enum logic {ST_IDLE, ST_BURST} state_t;

  // FIFO state
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        held_r, held_nxt;
  logic [ADDR_W-1:0]       head_r, head_nxt;
  logic [TOTAL_W-1:0]      wtot_r, wtot_nxt;
  logic [TOTAL_W-1:0]      rtot_r, rtot_nxt;
  logic                    closed_r, closed_nxt;
  logic [CAP_W-1:0]        cap_r;

  // Burst sequencer
  logic [BURST_W-1:0]      left_r, left_nxt;
  logic [ADDR_W-1:0]       rd_addr_r, rd_addr_nxt;

  // Output register
  logic                    ovalid_r, ovalid_nxt;
  logic                    obv_r, obv_nxt;
  logic                    olast_r, olast_nxt;
  logic                    owacc_r, owacc_nxt;
  logic                    oclamp_r, oclamp_nxt;
  logic [STAT_W-1:0]       ocount_r;
  logic [STAT_W-1:0]       ospace_r;
  logic [TOTAL_W-1:0]      owtot_r;
  logic [TOTAL_W-1:0]      ortot_r;
  logic                    oclosed_r;
  logic                    oeos_r;
  logic                    snap;

  // Store port
  logic                    mem_en, mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic [BYTE_W-1:0]       mem_q;

  // Decode helpers
  logic                    in_acc, out_free, cfg_wr, wr_ok, clamped;
  logic [CNT_W-1:0]        eff_cap;
  logic [CNT_W-1:0]        space_nxt;
  logic [BURST_W-1:0]      req, n;

  fcbf_store u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_data_byte),
    .rdata (mem_q)
  );

  // Handshakes
  assign out_free = !ovalid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Config port: always ready, one register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == fcbf_pkg::REG_CAPACITY);
  assign cfg_prdata = (cfg_paddr[2] == fcbf_pkg::REG_CAPACITY)
                      ? fcbf_pkg::CFG_DW'(cap_r) : '0;

  // Effective capacity, saturated at store depth
  always_comb begin
    if (fcbf_pkg::CAP_CMP_W'(cap_r) > fcbf_pkg::CAP_CMP_W'(fcbf_pkg::STORE_DEPTH)) begin
      eff_cap = CNT_W'(fcbf_pkg::STORE_DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  assign wr_ok = held_r < eff_cap;

  // Burst length: saturate, then clamp to what is held
  assign req = (in_burst_length > BURST_W'(fcbf_pkg::MAX_BURST))
               ? BURST_W'(fcbf_pkg::MAX_BURST) : in_burst_length;
  assign n   = (fcbf_pkg::CMP_W'(req) < fcbf_pkg::CMP_W'(held_r))
               ? req : BURST_W'(held_r);
  assign clamped = in_burst_length != n;

  // Sequencer and next-state logic
  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    head_nxt    = head_r;
    wtot_nxt    = wtot_r;
    rtot_nxt    = rtot_r;
    closed_nxt  = closed_r;
    left_nxt    = left_r;
    rd_addr_nxt = rd_addr_r;
    ovalid_nxt  = ovalid_r && out_stall;
    obv_nxt     = obv_r;
    olast_nxt   = olast_r;
    owacc_nxt   = owacc_r;
    oclamp_nxt  = oclamp_r;
    snap        = 1'b0;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = rd_addr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          snap       = 1'b1;
          ovalid_nxt = 1'b1;
          obv_nxt    = 1'b0;
          olast_nxt  = 1'b1;
          owacc_nxt  = 1'b0;
          oclamp_nxt = 1'b0;
          case (in_opcode)
            fcbf_pkg::OP_WRITE: begin
              owacc_nxt = wr_ok;
              if (wr_ok) begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = fcbf_pkg::ptr_add(head_r, held_r);
                held_nxt = held_r + CNT_W'(1);
                wtot_nxt = wtot_r + TOTAL_W'(1);
              end
            end
            fcbf_pkg::OP_READ, fcbf_pkg::OP_PEEK, fcbf_pkg::OP_DROP: begin
              oclamp_nxt = clamped;
              if (in_opcode != fcbf_pkg::OP_PEEK) begin
                head_nxt = fcbf_pkg::ptr_add(head_r, CNT_W'(n));
                held_nxt = held_r - CNT_W'(n);
                rtot_nxt = rtot_r + TOTAL_W'(n);
              end
              // first byte fetched now, rest streamed from the burst state
              if ((n != '0) && (in_opcode != fcbf_pkg::OP_DROP)) begin
                mem_en    = 1'b1;
                mem_addr  = head_r;
                obv_nxt   = 1'b1;
                olast_nxt = (n == BURST_W'(1));
                if (n != BURST_W'(1)) begin
                  state_nxt   = ST_BURST;
                  left_nxt    = n - BURST_W'(1);
                  rd_addr_nxt = fcbf_pkg::ptr_add(head_r, CNT_W'(1));
                end
              end
            end
            fcbf_pkg::OP_CLOSE: begin
              closed_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BURST: begin
        // one byte per beat while the output register frees up
        if (out_free) begin
          mem_en      = 1'b1;
          mem_addr    = rd_addr_r;
          ovalid_nxt  = 1'b1;
          olast_nxt   = (left_r == BURST_W'(1));
          left_nxt    = left_r - BURST_W'(1);
          rd_addr_nxt = fcbf_pkg::ptr_add(rd_addr_r, CNT_W'(1));
          if (left_r == BURST_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Free space after the step, zero when capacity was lowered below the count
  assign space_nxt = (eff_cap > held_nxt) ? (eff_cap - held_nxt) : '0;

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      held_r    <= '0;
      head_r    <= '0;
      wtot_r    <= '0;
      rtot_r    <= '0;
      closed_r  <= 1'b0;
      cap_r     <= fcbf_pkg::CAP_RESET;
      left_r    <= '0;
      rd_addr_r <= '0;
      ovalid_r  <= 1'b0;
      obv_r     <= 1'b0;
      olast_r   <= 1'b0;
      owacc_r   <= 1'b0;
      oclamp_r  <= 1'b0;
      ocount_r  <= '0;
      ospace_r  <= '0;
      owtot_r   <= '0;
      ortot_r   <= '0;
      oclosed_r <= 1'b0;
      oeos_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      held_r    <= held_nxt;
      head_r    <= head_nxt;
      wtot_r    <= wtot_nxt;
      rtot_r    <= rtot_nxt;
      closed_r  <= closed_nxt;
      left_r    <= left_nxt;
      rd_addr_r <= rd_addr_nxt;
      ovalid_r  <= ovalid_nxt;
      obv_r     <= obv_nxt;
      olast_r   <= olast_nxt;
      owacc_r   <= owacc_nxt;
      oclamp_r  <= oclamp_nxt;
      if (cfg_wr) begin
        cap_r <= cfg_pwdata[CAP_W-1:0];
      end
      // status is a snapshot taken when the item is accepted
      if (snap) begin
        ocount_r  <= STAT_W'(held_nxt);
        ospace_r  <= STAT_W'(space_nxt);
        owtot_r   <= wtot_nxt;
        ortot_r   <= rtot_nxt;
        oclosed_r <= closed_nxt;
        oeos_r    <= closed_nxt && (held_nxt == '0);
      end
    end
  end

  // Result beat
  assign out_valid           = ovalid_r;
  assign out_out_byte        = obv_r ? mem_q : '0;
  assign out_byte_valid      = obv_r;
  assign out_last_of_run     = olast_r;
  assign out_write_accepted  = owacc_r;
  assign out_request_clamped = oclamp_r;
  assign out_buffered_count  = ocount_r;
  assign out_remaining_space = ospace_r;
  assign out_total_written   = owtot_r;
  assign out_total_read      = ortot_r;
  assign out_input_closed    = oclosed_r;
  assign out_end_of_stream   = oeos_r;

endmodule

@@ tb/flow_controlled_byte_fifo_core_test.sv @@
// Self-checking testbench for flow_controlled_byte_fifo_core: commands go in, status beats come out.
// A FIFO predictor with its own ring store checks every beat; depends only on fcbf_pkg and the RTL.
module flow_controlled_byte_fifo_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fcbf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 4;
  localparam int OP_UNDEF_LO = int'(OP_CLOSE) + 1;
  localparam int OP_UNDEF_HI = 2 ** OP_W - 1;
  localparam logic [CFG_AW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [BYTE_W-1:0]  data;
    logic [BURST_W-1:0] burst;
  } command_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  obyte;
    logic               bvalid;
    logic               last;
    logic               wacc;
    logic               clamp;
    logic [STAT_W-1:0]  count;
    logic [STAT_W-1:0]  space;
    logic [TOTAL_W-1:0] wtot;
    logic [TOTAL_W-1:0] rtot;
    logic               closed;
    logic               eos;
  } result_beat_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // DUT ports
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode       = '0;
  logic [BYTE_W-1:0]    in_data_byte    = '0;
  logic [BURST_W-1:0]   in_burst_length = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [BYTE_W-1:0]    out_out_byte;
  logic                 out_byte_valid;
  logic                 out_last_of_run;
  logic                 out_write_accepted;
  logic                 out_request_clamped;
  logic [STAT_W-1:0]    out_buffered_count;
  logic [STAT_W-1:0]    out_remaining_space;
  logic [TOTAL_W-1:0]   out_total_written;
  logic [TOTAL_W-1:0]   out_total_read;
  logic                 out_input_closed;
  logic                 out_end_of_stream;
  logic                 cfg_psel    = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]    cfg_paddr   = '0;
  logic [CFG_DW-1:0]    cfg_pwdata  = '0;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  flow_controlled_byte_fifo_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_data_byte        (in_data_byte),
    .in_burst_length     (in_burst_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_out_byte        (out_out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_last_of_run     (out_last_of_run),
    .out_write_accepted  (out_write_accepted),
    .out_request_clamped (out_request_clamped),
    .out_buffered_count  (out_buffered_count),
    .out_remaining_space (out_remaining_space),
    .out_total_written   (out_total_written),
    .out_total_read      (out_total_read),
    .out_input_closed    (out_input_closed),
    .out_end_of_stream   (out_end_of_stream),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  // shadow FIFO state
  logic [BYTE_W-1:0] shadow_mem [STORE_DEPTH];
  int unsigned       shadow_head  = 0;
  int unsigned       shadow_held  = 0;
  logic [TOTAL_W-1:0] shadow_wtot = '0;
  logic [TOTAL_W-1:0] shadow_rtot = '0;
  logic              shadow_closed = 1'b0;
  logic [CAP_W-1:0]  shadow_cap    = CAP_RESET;

  command_t     command_q [$];
  result_beat_t expected_beats [$];
  command_t     cur_cmd;
  result_beat_t want;

  int  mismatches      = 0;
  int  beats_checked   = 0;
  int  commands_sent   = 0;
  int  cycle_count     = 0;
  int  send_gap        = 0;
  int  stall_run       = 0;
  int  hold_left       = 0;
  logic long_hold_done = 1'b0;
  logic no_idle        = 1'b0;

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // queue one status beat built from the shadow state after the step
  function automatic void expect_beat(input logic [BYTE_W-1:0] b, input logic v,
                                      input logic last, input logic acc, input logic clamp);
    result_beat_t e;
    int unsigned  cap_eff;
    cap_eff  = (shadow_cap > STORE_DEPTH) ? STORE_DEPTH : shadow_cap;
    e.obyte  = b;
    e.bvalid = v;
    e.last   = last;
    e.wacc   = acc;
    e.clamp  = clamp;
    e.count  = STAT_W'(shadow_held);
    e.space  = (cap_eff > shadow_held) ? STAT_W'(cap_eff - shadow_held) : '0;
    e.wtot   = shadow_wtot;
    e.rtot   = shadow_rtot;
    e.closed = shadow_closed;
    e.eos    = shadow_closed && (shadow_held == 0);
    expected_beats.insert(expected_beats.size(), e);
  endfunction

  // advance the shadow FIFO by one accepted command and queue its beats
  function automatic void apply_command(input command_t c);
    int unsigned       cap_eff, req, n, i;
    logic              clamp;
    logic [BYTE_W-1:0] got [MAX_BURST];
    cap_eff = (shadow_cap > STORE_DEPTH) ? STORE_DEPTH : shadow_cap;
    if (c.op == OP_WRITE) begin
      if (shadow_held < cap_eff) begin
        shadow_mem[(shadow_head + shadow_held) % STORE_DEPTH] = c.data;
        shadow_held++;
        shadow_wtot++;
        expect_beat('0, 1'b0, 1'b1, 1'b1, 1'b0);
      end else begin
        expect_beat('0, 1'b0, 1'b1, 1'b0, 1'b0);
      end
    end else if (c.op == OP_CLOSE) begin
      shadow_closed = 1'b1;
      expect_beat('0, 1'b0, 1'b1, 1'b0, 1'b0);
    end else if (c.op > OP_CLOSE) begin
      expect_beat('0, 1'b0, 1'b1, 1'b0, 1'b0);
    end else begin
      // read, peek, drop: saturate to max burst, then clamp to what is held
      req   = (c.burst > MAX_BURST) ? MAX_BURST : c.burst;
      n     = (req < shadow_held) ? req : shadow_held;
      clamp = (c.burst > n);
      for (i = 0; i < n; i++) got[i] = shadow_mem[(shadow_head + i) % STORE_DEPTH];
      if (c.op == OP_READ || c.op == OP_DROP) begin
        shadow_head = (shadow_head + n) % STORE_DEPTH;
        shadow_held -= n;
        shadow_rtot += n;
      end
      if (c.op == OP_DROP || n == 0) begin
        expect_beat('0, 1'b0, 1'b1, 1'b0, clamp);
      end else begin
        for (i = 0; i < n; i++) expect_beat(got[i], 1'b1, (i + 1 == n), 1'b0, clamp);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [TOTAL_W-1:0] exp_v,
                                      input logic [TOTAL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // driver: one command beat at a time from command_q, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(cur_cmd);
        commands_sent++;
      end
      if (in_valid && in_stall) begin
        // hold payload until taken
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (command_q.size() != 0) begin
        cur_cmd = command_q[0];
        command_q.delete(0);
        in_valid        <= 1'b1;
        in_opcode       <= cur_cmd.op;
        in_data_byte    <= cur_cmd.data;
        in_burst_length <= cur_cmd.burst;
        send_gap = no_idle ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random runs, plus one long hold while commands are still queued
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run = 0;
      hold_left = 0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && command_q.size() > 40) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_run != 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_run = no_idle ? 0 : pick_gap();
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        want = expected_beats[0];
        expected_beats.delete(0);
        check_field("out_byte", TOTAL_W'(want.obyte), TOTAL_W'(out_out_byte));
        check_field("byte_valid", TOTAL_W'(want.bvalid), TOTAL_W'(out_byte_valid));
        check_field("last_of_run", TOTAL_W'(want.last), TOTAL_W'(out_last_of_run));
        check_field("write_accepted", TOTAL_W'(want.wacc), TOTAL_W'(out_write_accepted));
        check_field("request_clamped", TOTAL_W'(want.clamp), TOTAL_W'(out_request_clamped));
        check_field("buffered_count", TOTAL_W'(want.count), TOTAL_W'(out_buffered_count));
        check_field("remaining_space", TOTAL_W'(want.space), TOTAL_W'(out_remaining_space));
        check_field("total_written", want.wtot, out_total_written);
        check_field("total_read", want.rtot, out_total_read);
        check_field("input_closed", TOTAL_W'(want.closed), TOTAL_W'(out_input_closed));
        check_field("end_of_stream", TOTAL_W'(want.eos), TOTAL_W'(out_end_of_stream));
        beats_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout: %0d predictions still pending", expected_beats.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                          input logic [BURST_W-1:0] burst);
    command_t c;
    c.op    = op;
    c.data  = data;
    c.burst = burst;
    command_q.insert(command_q.size(), c);
  endtask

  // random command mix; write_pct sets how fast the FIFO fills
  task automatic push_random(input int count, input int write_pct);
    int r, i, b;
    logic [OP_W-1:0] op;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < write_pct) op = OP_WRITE;
      else if (r < 94) op = OP_W'($urandom_range(int'(OP_READ), int'(OP_DROP)));
      else if (r < 98) op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      else op = OP_CLOSE;
      r = $urandom_range(0, 99);
      if (r < 80) b = $urandom_range(0, 12);
      else if (r < 95) b = $urandom_range(13, MAX_BURST);
      else b = $urandom_range(MAX_BURST + 1, 2 ** BURST_W - 1);
      push_cmd(op, BYTE_W'($urandom_range(0, 255)), BURST_W'(b));
    end
  endtask

  // wait until everything sent has been answered, then let the pipe settle
  task automatic wait_idle();
    while (command_q.size() != 0 || in_valid || expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write of the capacity register, only while idle
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    shadow_cap = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    no_idle     <= ($urandom_range(0, 3) == 0);
  endtask

  // stimulus sequence
  initial begin
    int i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty buffer, extremes of the data, bursts past the limit, close
    push_cmd(OP_READ, 8'h00, 7'd0);
    push_cmd(OP_PEEK, 8'hff, 7'd5);
    push_cmd(OP_DROP, 8'h00, 7'd3);
    push_cmd(OP_DROP, 8'h00, 7'd0);
    push_cmd(OP_WRITE, 8'h00, 7'd0);
    push_cmd(OP_WRITE, 8'hff, 7'h7f);
    push_cmd(OP_WRITE, 8'ha5, 7'd0);
    push_cmd(OP_WRITE, 8'h5a, 7'd0);
    push_cmd(OP_WRITE, 8'h80, 7'd0);
    push_cmd(OP_PEEK, 8'h00, 7'd2);
    push_cmd(OP_PEEK, 8'h00, 7'h7f);
    push_cmd(OP_READ, 8'h00, 7'd3);
    push_cmd(OP_DROP, 8'h00, 7'd1);
    push_cmd(OP_W'(OP_UNDEF_LO), 8'hff, 7'h7f);
    push_cmd(OP_W'(OP_UNDEF_HI), 8'h00, 7'd1);
    push_cmd(OP_CLOSE, 8'h00, 7'd0);
    push_cmd(OP_WRITE, 8'h7f, 7'd0);
    push_cmd(OP_READ, 8'h00, 7'd64);
    push_cmd(OP_READ, 8'h00, 7'd0);
    push_cmd(OP_W'(OP_UNDEF_LO + 1), 8'h55, 7'd0);
    push_cmd(OP_WRITE, 8'h01, 7'd0);
    wait_idle();

    // random traffic at the reset capacity
    push_random(5, 55);
    wait_idle();

    // capacity zero: every write refused
    set_capacity('0);
    push_random(3, 60);

    // capacity of one byte
    set_capacity(CAP_W'(1));
    push_random(4, 50);

    // lower the capacity below the held count
    set_capacity(CAP_W'(STORE_DEPTH));
    for (i = 0; i < 5; i++) push_cmd(OP_WRITE, BYTE_W'($urandom_range(0, 255)), '0);
    set_capacity(CAP_W'(3));
    push_random(4, 50);

    // capacity above the store depth; fill past one full burst, then drain at max
    set_capacity('1);
    for (i = 0; i < 65; i++) push_cmd(OP_WRITE, BYTE_W'($urandom_range(0, 255)), '0);
    push_cmd(OP_PEEK, 8'h00, 7'h7f);
    push_cmd(OP_READ, 8'h00, 7'd64);
    push_random(3, 45);

    // random capacity
    set_capacity(CAP_W'($urandom_range(1, STORE_DEPTH)));
    push_random(4, 50);
    wait_idle();

    $display("ran %0d commands and checked %0d result beats", commands_sent, beats_checked);
    $display("capacities 0, 1, 3, 4096, 8191 and random; long receiver hold %0s",
             long_hold_done ? "done" : "missed");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
